[src/rist_pkg.sv]
// ----------------------------------------------------------------------------
// rist_pkg: shared types and defaults of the inode slot table
// Item layouts, result status codes and default sizes of the table.
// ----------------------------------------------------------------------------
package rist_pkg;

    localparam int SLOTS_DEF             = 128;
    localparam int INODES_PER_SECTOR_DEF = 8;
    localparam int MAX_REFS_DEF          = 255;

    localparam int INODE_W  = 16;
    localparam int SLOT_W   = 7;
    localparam int LINK_W   = 8;
    localparam int ZONE_W   = 24;
    localparam int SECTOR_W = 25;

    typedef enum logic [3:0] {
        ST_HIT       = 4'd0,
        ST_LOADED    = 4'd1,
        ST_FULL      = 4'd2,
        ST_ROOT      = 4'd3,
        ST_DEC       = 4'd4,
        ST_WRITEBACK = 4'd5,
        ST_FREED     = 4'd6,
        ST_BADPUT    = 4'd7,
        ST_MAXED     = 4'd8
    } status_t;

    typedef enum logic {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic [INODE_W-1:0]        inode_number;
        logic [SLOT_W-1:0]         slot_index;
        logic signed [LINK_W-1:0]  link_count;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        status_t             status;
        logic [SECTOR_W-1:0] load_sector;
    } rsp_t;

endpackage

[src/refcounted_inode_slot_table_core.sv]
// ----------------------------------------------------------------------------
// refcounted_inode_slot_table_core: reference-counted inode slot table
// Caches inode numbers in a table of counted slots. A get finds or claims
// a slot, a put releases one and reports write-back or freeing on disk.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel (req_valid, req_stall, req) carries one get or put item.
//   The rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one result
//   item for each request item, in order. The cfg channel writes the first
//   sector of the inode zone and is always ready; write it only while idle.
//   The table lives in one synchronous memory of SLOTS entries that is read
//   one entry per cycle. A get walks the table in order until it hits or
//   has checked the last entry, then claims the first free slot or reports
//   a full table. A put reads one entry and may write back a lowered count;
//   a put to a slot beyond the table skips the read.
//   After reset the block sweeps the memory to zero, one entry per cycle,
//   and holds req_stall high until it ends. Configuration writes are taken
//   during the sweep.
//   The result sits in an output register, so a new item is accepted while
//   the previous result waits on rsp_stall. A finished result behind a
//   stalled one waits inside the block until the output register frees up.
// ----------------------------------------------------------------------------
module refcounted_inode_slot_table_core #(
    parameter int SLOTS             = rist_pkg::SLOTS_DEF,
    parameter int INODES_PER_SECTOR = rist_pkg::INODES_PER_SECTOR_DEF,
    parameter int MAX_REFS          = rist_pkg::MAX_REFS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  rist_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output rist_pkg::rsp_t              rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rist_pkg::ZONE_W-1:0] cfg_data
);
    import rist_pkg::*;

    localparam int AW    = $clog2(SLOTS);
    localparam int REF_W = $clog2(MAX_REFS + 1);
    // Exact division by a constant: q = (n * MUL) >> SH for all 16-bit n.
    localparam int DIV_SH = INODE_W + $clog2(INODES_PER_SECTOR);
    localparam longint unsigned DIV_MUL =
        ((64'd1 << DIV_SH) + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR;
    localparam int MUL_W = 18;

    typedef struct packed {
        logic [INODE_W-1:0] inode;
        logic [REF_W-1:0]   refs;
    } entry_t;

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        GET_SCAN,
        PUT_RD,
        PUT_CHK,
        DONE
    } state_t;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [AW:0]   scan_reg, scan_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          free_found_reg, free_found_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [INODE_W-1:0] q_reg;
    logic [ZONE_W-1:0]  zone_reg;
    rsp_t   res_reg, res_next;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;

    logic [INODE_W+MUL_W-1:0] prod;
    logic [AW+SLOT_W-1:0]     put_wide;
    logic [AW-1:0]            put_addr;
    logic                     put_idx_ok;
    logic [AW+SLOT_W-1:0]     chk_wide;
    logic [AW+SLOT_W-1:0]     fsel_wide;
    logic [AW-1:0]            fsel;
    logic                     issue;
    logic                     hit;
    logic                     cur_free;
    logic                     last;

    assign prod       = req_reg.inode_number * MUL_W'(DIV_MUL);
    assign put_wide   = {{AW{1'b0}}, req_reg.slot_index};
    assign put_addr   = put_wide[AW-1:0];
    assign put_idx_ok = {{(32-SLOT_W){1'b0}}, req.slot_index} < 32'(SLOTS);
    assign issue      = scan_reg < (AW+1)'(SLOTS);
    assign hit        = (rd_data_reg.refs != '0)
                        && (rd_data_reg.inode == req_reg.inode_number);
    assign cur_free   = rd_data_reg.refs == '0;
    assign last       = chk_idx_reg == AW'(SLOTS - 1);
    assign fsel       = free_found_reg ? free_idx_reg : chk_idx_reg;
    assign chk_wide   = {{SLOT_W{1'b0}}, chk_idx_reg};
    assign fsel_wide  = {{SLOT_W{1'b0}}, fsel};
    assign rd_addr    = (state_reg == GET_SCAN) ? scan_reg[AW-1:0] : put_addr;

    assign req_stall = state_reg != IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        scan_next       = scan_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        clr_next        = clr_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        wr_en           = 1'b0;
        wr_addr         = put_addr;
        wr_data         = rd_data_reg;

        unique case (state_reg)
            CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(SLOTS - 1))
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    res_next.slot        = req.slot_index;
                    res_next.status      = ST_BADPUT;
                    res_next.load_sector = '0;
                    if (req.mode == MODE_GET)
                    begin
                        state_next = GET_SCAN;
                    end
                    else if (put_idx_ok)
                    begin
                        state_next = PUT_RD;
                    end
                    else
                    begin
                        state_next = DONE;
                    end
                end
            end
            GET_SCAN:
            begin
                // Reads are issued one entry ahead of the check.
                if (issue)
                begin
                    scan_next = scan_reg + (AW+1)'(1);
                end
                chk_valid_next = issue;
                chk_idx_next   = scan_reg[AW-1:0];
                if (chk_valid_reg)
                begin
                    res_next.load_sector = '0;
                    if (hit)
                    begin
                        res_next.slot = chk_wide[SLOT_W-1:0];
                        if (rd_data_reg.refs == REF_W'(MAX_REFS))
                        begin
                            res_next.status = ST_MAXED;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = chk_idx_reg;
                            wr_data.inode   = rd_data_reg.inode;
                            wr_data.refs    = rd_data_reg.refs + REF_W'(1);
                            res_next.status = ST_HIT;
                        end
                        chk_valid_next = 1'b0;
                        state_next     = DONE;
                    end
                    else
                    begin
                        if (cur_free && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (last)
                        begin
                            if (free_found_reg || cur_free)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = fsel;
                                wr_data.inode = req_reg.inode_number;
                                wr_data.refs  = REF_W'(1);
                                res_next.slot        = fsel_wide[SLOT_W-1:0];
                                res_next.status      = ST_LOADED;
                                res_next.load_sector = SECTOR_W'(zone_reg)
                                                       + SECTOR_W'(q_reg);
                            end
                            else
                            begin
                                res_next.slot   = '0;
                                res_next.status = ST_FULL;
                            end
                            chk_valid_next = 1'b0;
                            state_next     = DONE;
                        end
                    end
                end
            end
            PUT_RD:
            begin
                state_next = PUT_CHK;
            end
            PUT_CHK:
            begin
                // The root check comes before the count check.
                priority if (rd_data_reg.inode == '0)
                begin
                    res_next.status = ST_ROOT;
                end
                else if (rd_data_reg.refs == '0)
                begin
                    res_next.status = ST_BADPUT;
                end
                else if (rd_data_reg.refs == REF_W'(1))
                begin
                    wr_en        = 1'b1;
                    wr_data.refs = '0;
                    res_next.status = (req_reg.link_count <= 8'sd0) ? ST_FREED
                                                                    : ST_WRITEBACK;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_data.refs = rd_data_reg.refs - REF_W'(1);
                    res_next.status = ST_DEC;
                end
                state_next = DONE;
            end
            DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            clr_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            zone_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                zone_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        q_reg          <= INODE_W'(prod >> DIV_SH);
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

    // The table is never written while the block waits for an item.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE || state_reg == DONE) |-> !wr_en)
        else $error("table written outside of item processing");

    // An accepted item always starts work in the next cycle.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != IDLE && state_reg != CLEAR))
        else $error("accepted item did not start");

    // Only a freshly loaded slot reports a sector.
    a_sector_loaded_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_LOADED) |-> (rsp.load_sector == '0))
        else $error("sector reported without a load");

    // A full table reports slot zero.
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.slot == '0))
        else $error("full result with nonzero slot");

endmodule
